FILE: rtl/swarq_pkg.sv
package swarq_pkg;

  localparam int MAX_PAYLOAD = 63;
  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W = $clog2(MAX_PAYLOAD);
  localparam logic [31:0] TIMEOUT_RESET = 32'd3000;
  localparam logic [15:0] CHK_MASK = 16'hFFFF;

  // request codes
  typedef enum logic [1:0] {
    REQ_APP     = 2'd0,
    REQ_RX_HDR  = 2'd1,
    REQ_RX_BYTE = 2'd2,
    REQ_TICK    = 2'd3
  } req_code_t;

  // packet item kinds
  localparam logic KIND_HDR  = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  typedef enum logic [1:0] {
    APP_IDLE    = 2'd0,
    APP_COLLECT = 2'd1,
    APP_DROP    = 2'd2
  } app_state_t;

  typedef enum logic [1:0] {
    TX_IDLE = 2'd0,
    TX_HDR  = 2'd1,
    TX_BODY = 2'd2
  } tx_state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  data_byte;
    logic        last_item;
    logic [31:0] rx_seq;
    logic [31:0] rx_ack_num;
    logic        rx_ack_flag;
    logic [15:0] rx_checksum;
  } req_item_t;

  typedef struct packed {
    logic        out_kind;
    logic        out_seq;
    logic [15:0] out_checksum;
    logic [7:0]  out_byte;
    logic        out_last;
  } pkt_item_t;

  // one send command for the back end
  typedef struct packed {
    logic             seq;
    logic [15:0]      chk;
    logic [LEN_W-1:0] len;
  } send_cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  // back pressure seen by the front end
  typedef struct packed {
    logic q_full;
    logic busy;
  } back_status_t;

endpackage

FILE: rtl/stop_and_wait_arq_sender.sv
// a header goes through the command queue and header state; payload bytes
//   follow one per cycle from the replay buffer read port unless stalled
// throughput: one request per cycle; app bytes wait while a packet replays,
//   and every request waits while both send-command slots are taken
// reset: synchronous, active high; clears control state, timeout back to 3000
module stop_and_wait_arq_sender (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  swarq_pkg::req_item_t req,
  output logic                 pkt_valid,
  input  logic                 pkt_stall,
  output swarq_pkg::pkt_item_t pkt
);
  import swarq_pkg::*;

  // front to queue
  logic         push;
  send_cmd_t    push_cmd;
  // queue to back
  logic         q_pop;
  send_cmd_t    q_head;
  logic         q_empty;
  logic         q_full;
  // front writes the replay buffer held in the back end
  store_wr_t    store_wr;
  logic         tx_busy;
  back_status_t status;

  // a send is still pending if the back end replays or a command waits
  assign status = '{q_full: q_full, busy: tx_busy || !q_empty};

  // front: takes every request kind, tracks sequence bit, ack wait, timer,
  // message collection and received packet checks
  swarq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .status    (status),
    .push      (push),
    .push_cmd  (push_cmd),
    .store_wr  (store_wr)
  );

  // two-entry queue of send commands (sequence bit, checksum, length)
  swarq_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back: replays header then stored bytes into the output register
  swarq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .store_wr  (store_wr),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .busy      (tx_busy),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt       (pkt)
  );

endmodule

FILE: rtl/swarq_front.sv
module swarq_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [31:0]             cfg_wdata,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  swarq_pkg::req_item_t    req,
  input  swarq_pkg::back_status_t status,
  output logic                    push,
  output swarq_pkg::send_cmd_t    push_cmd,
  output swarq_pkg::store_wr_t    store_wr
);
  import swarq_pkg::*;

  logic [31:0]      timeout_ticks;
  logic             seq_bit, seq_bit_next;
  logic             awaiting, awaiting_next;
  logic             present, present_next;
  logic [LEN_W-1:0] pay_len, pay_len_next;
  logic [15:0]      byte_sum, byte_sum_next;
  logic [15:0]      tx_chk, tx_chk_next;
  logic [31:0]      timer, timer_next;
  app_state_t       app_st, app_st_next;
  logic [15:0]      rx_sum, rx_sum_next;
  logic [31:0]      rx_ack, rx_ack_next;
  logic             rx_flag, rx_flag_next;
  logic [15:0]      rx_chk, rx_chk_next;
  logic             rx_open, rx_open_next;
  logic             accept;

  // app bytes wait while a replay still reads the store or a send command waits
  assign req_stall = status.q_full || (req.req_type == REQ_APP && status.busy);
  assign accept = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_bit  <= 1'b0;
      awaiting <= 1'b0;
      present  <= 1'b0;
      pay_len  <= '0;
      byte_sum <= '0;
      tx_chk   <= '0;
      timer    <= '0;
      app_st   <= APP_IDLE;
      rx_sum   <= '0;
      rx_ack   <= '0;
      rx_flag  <= 1'b0;
      rx_chk   <= '0;
      rx_open  <= 1'b0;
    end else begin
      seq_bit  <= seq_bit_next;
      awaiting <= awaiting_next;
      present  <= present_next;
      pay_len  <= pay_len_next;
      byte_sum <= byte_sum_next;
      tx_chk   <= tx_chk_next;
      timer    <= timer_next;
      app_st   <= app_st_next;
      rx_sum   <= rx_sum_next;
      rx_ack   <= rx_ack_next;
      rx_flag  <= rx_flag_next;
      rx_chk   <= rx_chk_next;
      rx_open  <= rx_open_next;
    end
  end

  always_comb begin
    logic        send;
    logic        do_eval;
    logic [15:0] ev_sum;
    logic [31:0] ev_ack;
    logic        ev_flag;
    logic [15:0] ev_chk;

    seq_bit_next  = seq_bit;
    awaiting_next = awaiting;
    present_next  = present;
    pay_len_next  = pay_len;
    byte_sum_next = byte_sum;
    tx_chk_next   = tx_chk;
    timer_next    = timer;
    app_st_next   = app_st;
    rx_sum_next   = rx_sum;
    rx_ack_next   = rx_ack;
    rx_flag_next  = rx_flag;
    rx_chk_next   = rx_chk;
    rx_open_next  = rx_open;
    store_wr      = '{en: 1'b0, addr: pay_len[ADDR_W-1:0], data: req.data_byte};
    send          = 1'b0;
    do_eval       = 1'b0;
    ev_sum        = rx_sum;
    ev_ack        = rx_ack;
    ev_flag       = rx_flag;
    ev_chk        = rx_chk;

    if (accept) begin
      unique case (req.req_type)
        REQ_APP: begin
          if (app_st_next == APP_IDLE) begin
            if (awaiting) begin
              app_st_next = APP_DROP;
            end else begin
              app_st_next   = APP_COLLECT;
              pay_len_next  = '0;
              byte_sum_next = '0;
              present_next  = 1'b0;
            end
          end
          if (app_st_next == APP_DROP) begin
            if (req.last_item) begin
              app_st_next = APP_IDLE;
            end
          end else begin
            if (pay_len_next < LEN_W'(MAX_PAYLOAD)) begin
              store_wr.en   = 1'b1;
              store_wr.addr = pay_len_next[ADDR_W-1:0];
              pay_len_next  = pay_len_next + LEN_W'(1);
              byte_sum_next = byte_sum_next + {8'h00, req.data_byte};
            end
            if (req.last_item) begin
              app_st_next   = APP_IDLE;
              tx_chk_next   = (byte_sum_next + {15'h0000, seq_bit}) & CHK_MASK;
              present_next  = 1'b1;
              awaiting_next = 1'b1;
              timer_next    = timeout_ticks;
              send          = 1'b1;
            end
          end
        end
        REQ_RX_HDR: begin
          rx_sum_next  = req.rx_seq[15:0];
          rx_ack_next  = req.rx_ack_num;
          rx_flag_next = req.rx_ack_flag;
          rx_chk_next  = req.rx_checksum;
          rx_open_next = 1'b1;
          ev_sum       = req.rx_seq[15:0];
          ev_ack       = req.rx_ack_num;
          ev_flag      = req.rx_ack_flag;
          ev_chk       = req.rx_checksum;
          do_eval      = req.last_item;
        end
        REQ_RX_BYTE: begin
          if (rx_open) begin
            ev_sum      = rx_sum + {8'h00, req.data_byte};
            rx_sum_next = ev_sum;
            do_eval     = req.last_item;
          end
        end
        REQ_TICK: begin
          if (awaiting) begin
            if (timer <= 32'd1) begin
              timer_next = timeout_ticks;
              send       = 1'b1;
            end else begin
              timer_next = timer - 32'd1;
            end
          end
        end
        default: ;
      endcase

      if (do_eval) begin
        rx_open_next = 1'b0;
        if (awaiting) begin
          if (ev_sum != ev_chk || (ev_flag && ev_ack != {31'd0, seq_bit})) begin
            timer_next = timeout_ticks;
            send       = 1'b1;
          end else if (ev_flag) begin
            awaiting_next = 1'b0;
            timer_next    = '0;
            seq_bit_next  = ~seq_bit;
          end
        end
      end
    end

    push     = send && present_next;
    push_cmd = '{seq: seq_bit_next, chk: tx_chk_next, len: pay_len_next};
  end

endmodule

FILE: rtl/swarq_cmd_fifo.sv
module swarq_cmd_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  swarq_pkg::send_cmd_t push_cmd,
  input  logic                 pop,
  output swarq_pkg::send_cmd_t head,
  output logic                 empty,
  output logic                 full
);
  import swarq_pkg::*;

  send_cmd_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = slots[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/swarq_back.sv
module swarq_back (
  input  logic                 clk,
  input  logic                 rst,
  input  swarq_pkg::store_wr_t store_wr,
  input  logic                 q_empty,
  input  swarq_pkg::send_cmd_t q_head,
  output logic                 q_pop,
  output logic                 busy,
  output logic                 pkt_valid,
  input  logic                 pkt_stall,
  output swarq_pkg::pkt_item_t pkt
);
  import swarq_pkg::*;

  logic [7:0]       store [MAX_PAYLOAD];
  tx_state_t        tx_st, tx_st_next;
  send_cmd_t        cmd, cmd_next;
  logic [LEN_W-1:0] fetch_idx, fetch_idx_next;
  logic [LEN_W-1:0] emit_idx, emit_idx_next;
  logic             rd_v, rd_v_next;
  logic [7:0]       rd_q;
  logic             rd_en;
  logic             load_ok;
  logic             load_hdr;
  logic             load_byte;
  logic             out_v;
  pkt_item_t        out_q;

  assign busy      = (tx_st != TX_IDLE);
  assign pkt_valid = out_v;
  assign pkt       = out_q;
  assign load_ok   = !out_v || !pkt_stall;

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      store[store_wr.addr] <= store_wr.data;
    end
    if (rd_en) begin
      rd_q <= store[fetch_idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_st     <= TX_IDLE;
      fetch_idx <= '0;
      emit_idx  <= '0;
      rd_v      <= 1'b0;
    end else begin
      tx_st     <= tx_st_next;
      fetch_idx <= fetch_idx_next;
      emit_idx  <= emit_idx_next;
      rd_v      <= rd_v_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
  end

  always_comb begin
    tx_st_next     = tx_st;
    cmd_next       = cmd;
    fetch_idx_next = fetch_idx;
    emit_idx_next  = emit_idx;
    q_pop          = 1'b0;
    load_hdr       = 1'b0;
    load_byte      = 1'b0;
    rd_en          = 1'b0;

    unique case (tx_st)
      TX_IDLE: begin
        if (!q_empty) begin
          q_pop          = 1'b1;
          cmd_next       = q_head;
          tx_st_next     = TX_HDR;
          fetch_idx_next = '0;
          emit_idx_next  = '0;
        end
      end
      TX_HDR: begin
        if (load_ok) begin
          load_hdr   = 1'b1;
          tx_st_next = (cmd.len == '0) ? TX_IDLE : TX_BODY;
        end
      end
      TX_BODY: begin
        if (rd_v && load_ok) begin
          load_byte     = 1'b1;
          emit_idx_next = emit_idx + LEN_W'(1);
          if (emit_idx + LEN_W'(1) == cmd.len) begin
            tx_st_next = TX_IDLE;
          end
        end
      end
      default: tx_st_next = TX_IDLE;
    endcase

    // one byte of prefetch ahead of the output register
    if (tx_st != TX_IDLE && fetch_idx < cmd.len && (!rd_v || load_byte)) begin
      rd_en          = 1'b1;
      fetch_idx_next = fetch_idx + LEN_W'(1);
    end

    if (rd_en) begin
      rd_v_next = 1'b1;
    end else if (load_byte) begin
      rd_v_next = 1'b0;
    end else begin
      rd_v_next = rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (load_hdr || load_byte) begin
      out_v <= 1'b1;
    end else if (!pkt_stall) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_hdr) begin
      out_q <= '{out_kind: KIND_HDR, out_seq: cmd.seq, out_checksum: cmd.chk,
                 out_byte: 8'h00, out_last: (cmd.len == '0)};
    end else if (load_byte) begin
      out_q <= '{out_kind: KIND_BYTE, out_seq: cmd.seq, out_checksum: 16'h0000,
                 out_byte: rd_q, out_last: (emit_idx + LEN_W'(1) == cmd.len)};
    end
  end

endmodule

FILE: rtl/swarq_checker.sv
module swarq_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 pkt_valid,
  input logic                 pkt_stall,
  input swarq_pkg::pkt_item_t pkt
);
  import swarq_pkg::*;

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !pkt_valid)
    else $error("packet valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_stall |=> pkt_valid && $stable(pkt))
    else $error("stalled packet item changed");

  a_byte_no_chk: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt.out_kind == KIND_BYTE |-> pkt.out_checksum == 16'h0000)
    else $error("payload item carries a checksum");

  a_hdr_no_byte: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt.out_kind == KIND_HDR |-> pkt.out_byte == 8'h00)
    else $error("header item carries a byte");

endmodule

bind stop_and_wait_arq_sender swarq_checker u_chk (.*);

FILE: tb/stop_and_wait_arq_sender_tb.sv
`timescale 1ns / 100ps

module stop_and_wait_arq_sender_tb;
  import swarq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // drain tail: leave margin for the replay
  localparam int DRAIN_TAIL = 20;
  localparam int FAULT_PRINTS = 10;

  typedef enum {RPL_ACK, RPL_BAD_CHK, RPL_WRONG_ACK, RPL_NO_FLAG} reply_kind_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_item_t   req = '0;
  logic        pkt_valid;
  logic        pkt_stall = 1'b0;
  pkt_item_t   pkt;

  // predicted sender state, advanced once per accepted request
  logic              cur_seq;
  logic              wait_ack;
  logic              have_packet;
  logic [7:0]        buf_bytes [MAX_PAYLOAD];
  logic [LEN_W-1:0]  buf_len;
  logic [15:0]       buf_chk;
  logic [31:0]       ticks_left;
  logic [31:0]       ticks_reload;
  app_state_t        app_phase;
  logic [15:0]       reply_sum;
  logic [31:0]       reply_ack;
  logic              reply_flag;
  logic [15:0]       reply_chk;
  logic              reply_open;

  // packet items the sender still owes us, oldest first
  pkt_item_t owed_pkt_items[$];

  int fault_count = 0;
  int n_requests = 0;
  int cycle_count = 0;
  int hold_request = 0;
  int hold_left = 0;
  bit no_idle = 1'b0;

  stop_and_wait_arq_sender dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt       (pkt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // sender prediction
  // ---------------------------------------------------------------------

  // arm the timer and queue the whole stored packet, header first
  function automatic void rearm_and_resend();
    int i;
    ticks_left = ticks_reload;
    if (have_packet) begin
      owed_pkt_items.push_back(pkt_item_t'{KIND_HDR, cur_seq, buf_chk, 8'd0, buf_len == 0});
      for (i = 0; i < buf_len; i++)
        owed_pkt_items.push_back(pkt_item_t'{KIND_BYTE, cur_seq, 16'd0, buf_bytes[i],
                                             i + 1 == buf_len});
    end
  endfunction

  // a received packet is complete: retransmit, advance, or nothing
  function automatic void judge_reply();
    reply_open = 1'b0;
    if (!wait_ack)
      return;
    if (reply_sum != reply_chk || (reply_flag && reply_ack != {31'd0, cur_seq})) begin
      rearm_and_resend();
    end else if (reply_flag) begin
      wait_ack = 1'b0;
      ticks_left = '0;
      cur_seq = ~cur_seq;
    end
  endfunction

  function automatic void advance_sender(req_item_t r);
    logic [15:0] sum;
    int i;
    case (req_code_t'(r.req_type))
      REQ_APP: begin
        if (app_phase == APP_IDLE) begin
          // first byte of a message: drop it whole if still waiting on an ACK
          if (wait_ack) begin
            app_phase = APP_DROP;
          end else begin
            app_phase = APP_COLLECT;
            buf_len = '0;
            have_packet = 1'b0;
          end
        end
        if (app_phase == APP_DROP) begin
          if (r.last_item)
            app_phase = APP_IDLE;
        end else begin
          // bytes past the buffer are lost and not summed
          if (buf_len < MAX_PAYLOAD) begin
            buf_bytes[buf_len] = r.data_byte;
            buf_len++;
          end
          if (r.last_item) begin
            app_phase = APP_IDLE;
            sum = {15'd0, cur_seq};
            for (i = 0; i < buf_len; i++)
              sum += buf_bytes[i];
            buf_chk = sum;
            have_packet = 1'b1;
            wait_ack = 1'b1;
            rearm_and_resend();
          end
        end
      end
      REQ_RX_HDR: begin
        // a new header always restarts the received packet
        reply_sum = r.rx_seq[15:0];
        reply_ack = r.rx_ack_num;
        reply_flag = r.rx_ack_flag;
        reply_chk = r.rx_checksum;
        reply_open = 1'b1;
        if (r.last_item)
          judge_reply();
      end
      REQ_RX_BYTE: begin
        if (reply_open) begin
          reply_sum += r.data_byte;
          if (r.last_item)
            judge_reply();
        end
      end
      default: begin
        // tick: a reload of zero fires on the very next tick, like one
        if (wait_ack) begin
          if (ticks_left <= 1)
            rearm_and_resend();
          else
            ticks_left--;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // result checking and the receiving side
  // ---------------------------------------------------------------------

  task automatic log_fault(string what, pkt_item_t e, pkt_item_t a);
    fault_count++;
    if (fault_count <= FAULT_PRINTS) begin
      $write("%0t %s: exp kind=%0d seq=%0d chk=%h byte=%h last=%0d", $time, what,
             e.out_kind, e.out_seq, e.out_checksum, e.out_byte, e.out_last);
      $display(" | got kind=%0d seq=%0d chk=%h byte=%h last=%0d",
               a.out_kind, a.out_seq, a.out_checksum, a.out_byte, a.out_last);
    end
  endtask

  always @(posedge clk) begin
    pkt_item_t e;
    if (!rst && pkt_valid && !pkt_stall) begin
      if (owed_pkt_items.size() == 0) begin
        log_fault("unexpected packet item", '0, pkt);
      end else begin
        e = owed_pkt_items.pop_front();
        if (pkt.out_kind !== e.out_kind || pkt.out_seq !== e.out_seq ||
            pkt.out_checksum !== e.out_checksum || pkt.out_byte !== e.out_byte ||
            pkt.out_last !== e.out_last)
          log_fault("packet item mismatch", e, pkt);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when a test asks for one
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pkt_stall <= 1'b1;
    end else begin
      pkt_stall <= !no_idle && ($urandom_range(99) < 22);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // request building and driving
  // ---------------------------------------------------------------------

  // every field random, so unused fields still toggle
  function automatic req_item_t rand_item();
    req_item_t r;
    r.req_type = 2'($urandom_range(3));
    r.data_byte = 8'($urandom);
    r.last_item = 1'($urandom);
    r.rx_seq = $urandom;
    r.rx_ack_num = $urandom;
    r.rx_ack_flag = 1'($urandom);
    r.rx_checksum = 16'($urandom);
    return r;
  endfunction

  function automatic req_item_t shaped(req_code_t code, logic [7:0] b, logic last);
    req_item_t r;
    r = rand_item();
    r.req_type = code;
    r.data_byte = b;
    r.last_item = last;
    return r;
  endfunction

  task automatic send_request(req_item_t r);
    while (!no_idle && $urandom_range(99) < 22) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    advance_sender(r);
    n_requests++;
  endtask

  task automatic send_tick();
    send_request(shaped(REQ_TICK, 8'($urandom), 1'($urandom)));
  endtask

  task automatic send_message(int len);
    int i;
    for (i = 0; i < len; i++)
      send_request(shaped(REQ_APP, 8'($urandom), i == len - 1));
  endtask

  // one received packet: header plus nb payload bytes, shaped by kind
  task automatic send_reply(reply_kind_t kind, int nb);
    req_item_t h;
    logic [7:0] body [4];
    logic [15:0] sum;
    int i;
    h = shaped(REQ_RX_HDR, 8'($urandom), nb == 0);
    sum = h.rx_seq[15:0];
    for (i = 0; i < nb; i++) begin
      body[i] = 8'($urandom);
      sum += body[i];
    end
    h.rx_checksum = sum;
    h.rx_ack_flag = 1'b1;
    h.rx_ack_num = {31'd0, cur_seq};
    case (kind)
      RPL_BAD_CHK: begin
        h.rx_checksum = sum ^ 16'($urandom_range(1, 16'hFFFF));
        h.rx_ack_flag = 1'($urandom);
      end
      RPL_WRONG_ACK:
        h.rx_ack_num = {31'd0, cur_seq} ^ ($urandom_range(1) ? 32'd1 : ($urandom | 32'd1));
      RPL_NO_FLAG: begin
        h.rx_ack_flag = 1'b0;
        h.rx_ack_num = $urandom;
      end
      default: ;
    endcase
    send_request(h);
    for (i = 0; i < nb; i++)
      send_request(shaped(REQ_RX_BYTE, body[i], i == nb - 1));
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (owed_pkt_items.size() != 0);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // only called with the sender idle
  task automatic set_timeout(logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ticks_reload = v;
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  task automatic test_directed();
    req_item_t h;
    // nothing pending: stray payload byte, tick and a clean ACK are ignored
    send_request(shaped(REQ_RX_BYTE, 8'hFF, 1'b1));
    send_tick();
    send_reply(RPL_ACK, 0);
    // one-byte message goes out with sequence 0
    send_request(shaped(REQ_APP, 8'hFF, 1'b1));
    send_tick();
    // message arriving while busy is dropped whole
    send_request(shaped(REQ_APP, 8'h00, 1'b0));
    send_request(shaped(REQ_APP, 8'hA5, 1'b1));
    // intact packet without the ACK flag changes nothing
    send_reply(RPL_NO_FLAG, 0);
    // bad checksum retransmits
    send_reply(RPL_BAD_CHK, 0);
    // ACK for the wrong number, all-ones header fields
    h = shaped(REQ_RX_HDR, 8'h00, 1'b1);
    h.rx_seq = 32'hFFFF_FFFF;
    h.rx_ack_num = 32'hFFFF_FFFF;
    h.rx_ack_flag = 1'b1;
    h.rx_checksum = 16'hFFFF;
    send_request(h);
    // an open header is restarted by the next one, which ACKs
    h = shaped(REQ_RX_HDR, 8'h00, 1'b0);
    h.rx_checksum = h.rx_seq[15:0] + 16'd1;
    send_request(h);
    send_reply(RPL_ACK, 0);
    // sequence 1, extreme bytes
    send_request(shaped(REQ_APP, 8'h00, 1'b0));
    send_request(shaped(REQ_APP, 8'hFF, 1'b0));
    send_request(shaped(REQ_APP, 8'h80, 1'b1));
    // ACK with payload whose sum wraps past 16 bits
    h = shaped(REQ_RX_HDR, 8'h00, 1'b0);
    h.rx_seq = 32'h0000_FFFF;
    h.rx_ack_num = 32'd1;
    h.rx_ack_flag = 1'b1;
    h.rx_checksum = 16'h01FD;
    send_request(h);
    send_request(shaped(REQ_RX_BYTE, 8'hFF, 1'b0));
    send_request(shaped(REQ_RX_BYTE, 8'hFF, 1'b1));
    wait_drained();
  endtask

  // zero, one and all-ones reload values
  task automatic test_timeout_extremes();
    logic [31:0] reloads [3];
    int k;
    reloads = '{32'd0, 32'd1, 32'hFFFF_FFFF};
    for (k = 0; k < 3; k++) begin
      set_timeout(reloads[k]);
      send_message(2);
      repeat (3) send_tick();
      send_reply(RPL_ACK, 1);
      wait_drained();
    end
  endtask

  // more bytes than the buffer holds, then one timed-out resend
  task automatic test_long_message();
    set_timeout(32'd2);
    send_message(MAX_PAYLOAD + 3);
    send_tick();
    send_tick();
    send_reply(RPL_ACK, 0);
    wait_drained();
  endtask

  // receiver holds off while resends pile up, so the block stalls requests
  task automatic test_backpressure();
    set_timeout(32'd1);
    hold_request = 400;
    send_message(20);
    repeat (4) send_tick();
    send_reply(RPL_ACK, 2);
    wait_drained();
  endtask

  // message, some mix of ticks, bad replies and busy drops, then the ACK
  task automatic run_exchange();
    int len, k;
    len = ($urandom_range(9) == 0) ? $urandom_range(1, MAX_PAYLOAD) : $urandom_range(1, 6);
    send_message(len);
    repeat ($urandom_range(4)) begin
      k = $urandom_range(9);
      if (k < 4)
        send_tick();
      else if (k < 6)
        send_reply(RPL_BAD_CHK, $urandom_range(3));
      else if (k < 7)
        send_reply(RPL_WRONG_ACK, $urandom_range(3));
      else if (k < 8)
        send_reply(RPL_NO_FLAG, $urandom_range(3));
      else
        send_message($urandom_range(1, 3));
    end
    send_reply(RPL_ACK, $urandom_range(3));
  endtask

  task automatic random_phase(int quota);
    int first;
    first = n_requests;
    while (n_requests - first < quota) begin
      if ($urandom_range(99) < 80)
        run_exchange();
      else
        repeat ($urandom_range(1, 3)) send_request(rand_item());
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    set_timeout($urandom_range(1, 4));
    random_phase(40);
    // a stretch where neither side idles
    no_idle = 1'b1;
    set_timeout($urandom_range(1, 4));
    random_phase(40);
    no_idle = 1'b0;
    set_timeout($urandom_range(2, 6));
    random_phase(40);
  endtask

  initial begin
    cur_seq = 1'b0;
    wait_ack = 1'b0;
    have_packet = 1'b0;
    buf_len = '0;
    buf_chk = '0;
    ticks_left = '0;
    ticks_reload = TIMEOUT_RESET;
    app_phase = APP_IDLE;
    reply_sum = '0;
    reply_ack = '0;
    reply_flag = 1'b0;
    reply_chk = '0;
    reply_open = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_timeout_extremes();
    test_long_message();
    test_backpressure();
    test_random_traffic();

    if (fault_count == 0 && owed_pkt_items.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
